### hdl/llq_pkg.sv
package llq_pkg;

  localparam int unsigned POOL_NODES = 16;
  // node index width and pointer width (pointer also codes null)
  localparam int unsigned IDX_W = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned PTR_W = $clog2(POOL_NODES + 1);
  localparam int unsigned VAL_W = 32;

  localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(POOL_NODES);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

endpackage

### hdl/linked_list_queue_free_pool.sv
// fifo queue of 32-bit values kept as a linked list in a pool of
// llq_pkg::POOL_NODES nodes, unused nodes chained on a free list. a command
// beat is taken when start is high and busy is low; the node link memory
// has a registered read: the link of the free-list head (enqueue) or of the
// queue head (dequeue) is read in the accept cycle, and that head moves on
// to the read link in the next, during which
// busy is high. the result beat (value_out_o, status_o) appears with
// result_valid_o for exactly one cycle, in the cycle after busy falls, and
// must be taken then: the receiver cannot stall the block. a new command may
// be accepted in that same cycle. status 1 is overflow (no free node),
// status 2 underflow (queue empty); both leave the state unchanged and
// return value zero. after reset the pool is chained in index order and the
// queue is empty at once: per-entry valid bits stand for the reset links,
// so there is no clearing pass.
module linked_list_queue_free_pool (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [31:0] value_in_i,
  output logic [31:0] value_out_o,
  output logic [1:0]  status_o,
  output logic        result_valid_o
);

  // node storage: value memory has no reset, link memory has valid bits
  logic [llq_pkg::VAL_W-1:0] value_mem [llq_pkg::POOL_NODES];
  llq_pkg::ptr_t             link_mem  [llq_pkg::POOL_NODES];
  logic [llq_pkg::POOL_NODES-1:0] link_vld_q;

  // list pointers
  llq_pkg::ptr_t free_head_q, queue_head_q, queue_tail_q;

  llq_pkg::state_e  state_q;
  llq_pkg::action_e op_q;
  llq_pkg::status_e st_q;
  llq_pkg::idx_t    node_q;      // node being dequeued
  logic             last_q;      // dequeue of the only node

  // registered read side
  llq_pkg::idx_t             rd_addr_q;
  llq_pkg::ptr_t             link_rd_q;
  logic                      link_rd_vld_q;
  logic [llq_pkg::VAL_W-1:0] value_rd_q;
  llq_pkg::ptr_t             link_rdata;

  logic [llq_pkg::VAL_W-1:0] value_out_q;
  llq_pkg::status_e          status_out_q;
  logic                      out_vld_q;

  logic          accept, free_ok, queue_ok;
  llq_pkg::idx_t rd_addr;
  logic          link_we;
  llq_pkg::idx_t link_waddr;
  llq_pkg::ptr_t link_wdata;

  assign busy     = (state_q == llq_pkg::S_EXEC);
  assign accept   = start && !busy;
  assign free_ok  = (free_head_q != llq_pkg::NIL_PTR);
  assign queue_ok = (queue_head_q != llq_pkg::NIL_PTR);

  // enqueue reads the free-list head link, dequeue the queue head link
  assign rd_addr = (llq_pkg::action_e'(action_i) == llq_pkg::ACT_ENQ)
                   ? free_head_q[llq_pkg::IDX_W-1:0]
                   : queue_head_q[llq_pkg::IDX_W-1:0];

  // an entry never written still holds its reset link, index plus one
  assign link_rdata = link_rd_vld_q ? link_rd_q
                                    : llq_pkg::PTR_W'(rd_addr_q) + llq_pkg::PTR_W'(1);

  // single link write port: enqueue appends at accept, dequeue frees in exec
  always_comb begin
    link_we    = 1'b0;
    link_waddr = queue_tail_q[llq_pkg::IDX_W-1:0];
    link_wdata = free_head_q;
    if (accept && llq_pkg::action_e'(action_i) == llq_pkg::ACT_ENQ && free_ok &&
        queue_ok) begin
      link_we = 1'b1;
    end else if (busy && op_q == llq_pkg::ACT_DEQ && st_q == llq_pkg::ST_DONE) begin
      link_we    = 1'b1;
      link_waddr = node_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (accept && llq_pkg::action_e'(action_i) == llq_pkg::ACT_ENQ && free_ok) begin
      value_mem[free_head_q[llq_pkg::IDX_W-1:0]] <= value_in_i;
    end
    if (accept) begin
      rd_addr_q  <= rd_addr;
      link_rd_q  <= link_mem[rd_addr];
      value_rd_q <= value_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q    <= '0;
      link_rd_vld_q <= 1'b0;
    end else begin
      if (link_we) begin
        link_vld_q[link_waddr] <= 1'b1;
      end
      if (accept) begin
        link_rd_vld_q <= link_vld_q[rd_addr];
      end
    end
  end

  // command sequencing and pointer updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= llq_pkg::S_IDLE;
      free_head_q  <= '0;
      queue_head_q <= llq_pkg::NIL_PTR;
      queue_tail_q <= llq_pkg::NIL_PTR;
      out_vld_q    <= 1'b0;
      op_q         <= llq_pkg::ACT_ENQ;
      st_q         <= llq_pkg::ST_DONE;
    end else begin
      out_vld_q <= 1'b0;
      case (state_q)
        llq_pkg::S_IDLE: begin
          if (start) begin
            state_q <= llq_pkg::S_EXEC;
            op_q    <= llq_pkg::action_e'(action_i);
            if (llq_pkg::action_e'(action_i) == llq_pkg::ACT_ENQ) begin
              if (free_ok) begin
                st_q         <= llq_pkg::ST_DONE;
                queue_tail_q <= free_head_q;
                if (!queue_ok) begin
                  queue_head_q <= free_head_q;
                end
              end else begin
                st_q <= llq_pkg::ST_OVERFLOW;
              end
            end else begin
              st_q <= queue_ok ? llq_pkg::ST_DONE : llq_pkg::ST_UNDERFLOW;
            end
          end
        end
        llq_pkg::S_EXEC: begin
          state_q   <= llq_pkg::S_IDLE;
          out_vld_q <= 1'b1;
          if (st_q == llq_pkg::ST_DONE) begin
            if (op_q == llq_pkg::ACT_ENQ) begin
              free_head_q <= link_rdata;
            end else begin
              // the tail link is never needed: head equal to tail empties
              if (last_q) begin
                queue_head_q <= llq_pkg::NIL_PTR;
                queue_tail_q <= llq_pkg::NIL_PTR;
              end else begin
                queue_head_q <= link_rdata;
              end
              free_head_q <= llq_pkg::PTR_W'(node_q);
            end
          end
        end
        default: begin
          state_q <= llq_pkg::S_IDLE;
        end
      endcase
    end
  end

  // per-command payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      node_q <= queue_head_q[llq_pkg::IDX_W-1:0];
      last_q <= (queue_head_q == queue_tail_q);
    end
    if (busy) begin
      status_out_q <= st_q;
      value_out_q  <= (op_q == llq_pkg::ACT_DEQ && st_q == llq_pkg::ST_DONE)
                      ? value_rd_q : '0;
    end
  end

  assign result_valid_o = out_vld_q;
  assign value_out_o    = value_out_q;
  assign status_o       = status_out_q;

endmodule

### hdl/llq_checker.sv
module llq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        action_i,
  input logic [31:0] value_in_i,
  input logic [31:0] value_out_o,
  input logic [1:0]  status_o,
  input logic        result_valid_o
);

  logic unused_in;
  assign unused_in = action_i ^ (^value_in_i);

  // an accepted beat makes the block busy in the cycle after
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_busy_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // every command yields its result right after busy
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> result_valid_o)
    else $error("result beat missing after busy");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != llq_pkg::ST_DONE |-> value_out_o == 32'd0)
    else $error("error result carries a nonzero value");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

endmodule

bind linked_list_queue_free_pool llq_checker u_llq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .action_i       (action_i),
  .value_in_i     (value_in_i),
  .value_out_o    (value_out_o),
  .status_o       (status_o),
  .result_valid_o (result_valid_o)
);
